### src/positional_list_insert_delete_defines.svh
// Assertion macros shared by the positional list checker.
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH

// Clocked assertion, quiet while reset is held.
`define PLID_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define PLID_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/plid_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package plid_pkg;

  localparam int DEPTH  = 128;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W  = 8;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int ITEM_W = 32;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;
  localparam int OUTCNT_W = 8;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_STEP,
    S_SHIFT,
    S_READ
  } state_t;

  typedef struct packed {
    logic              latch_in;    // capture the accepted transaction
    logic              load_idx_ins; // idx <= count
    logic              load_idx_del; // idx <= position
    logic              rd_pos;      // read entry at position
    logic              rd_step;     // read neighbor of idx
    logic              wr_shift;    // write read data at idx, step idx
    logic              wr_item;     // write item at position
    logic              inc;
    logic              dec;
    logic              load_res;
    logic [STAT_W-1:0] res_status;
    logic              res_use_rdata;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            pos_le_count;
    logic            pos_lt_count;
    logic            full;
    logic            ins_at_pos;   // insert: idx reached position
    logic            del_tail;     // delete: idx is the last entry
  } stat_t;

endpackage

### src/plid_ctrl.sv
// Controller state machine for the positional list.
module plid_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  plid_pkg::stat_t stat,
  output plid_pkg::cmd_t  cmd
);

  plid_pkg::state_t state, state_next;
  logic out_valid;
  logic fin_ok;

  assign fin_ok   = !out_valid || m_tready;
  assign s_tready = (state == plid_pkg::S_IDLE) && !rst;
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= plid_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_res) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      plid_pkg::S_IDLE: begin
        if (s_tvalid) state_next = plid_pkg::S_CHECK;
      end
      plid_pkg::S_CHECK: begin
        case (stat.op)
          plid_pkg::OP_INSERT: begin
            if (!stat.pos_le_count || stat.full) begin
              if (fin_ok) state_next = plid_pkg::S_IDLE;
            end else begin
              state_next = plid_pkg::S_STEP;
            end
          end
          plid_pkg::OP_DELETE: begin
            if (stat.pos_lt_count) begin
              state_next = plid_pkg::S_STEP;
            end else if (fin_ok) begin
              state_next = plid_pkg::S_IDLE;
            end
          end
          plid_pkg::OP_READ: begin
            if (stat.pos_lt_count) begin
              state_next = plid_pkg::S_READ;
            end else if (fin_ok) begin
              state_next = plid_pkg::S_IDLE;
            end
          end
          default: begin
            if (fin_ok) state_next = plid_pkg::S_IDLE;
          end
        endcase
      end
      plid_pkg::S_STEP: begin
        if ((stat.op == plid_pkg::OP_INSERT) ? stat.ins_at_pos : stat.del_tail) begin
          if (fin_ok) state_next = plid_pkg::S_IDLE;
        end else begin
          state_next = plid_pkg::S_SHIFT;
        end
      end
      plid_pkg::S_SHIFT: begin
        state_next = plid_pkg::S_STEP;
      end
      plid_pkg::S_READ: begin
        if (fin_ok) state_next = plid_pkg::S_IDLE;
      end
      default: begin
        state_next = plid_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_status = plid_pkg::ST_BADPOS;
    unique case (state)
      plid_pkg::S_IDLE: begin
        cmd.latch_in = s_tvalid;
      end
      plid_pkg::S_CHECK: begin
        case (stat.op)
          plid_pkg::OP_INSERT: begin
            if (!stat.pos_le_count) begin
              cmd.load_res = fin_ok;
            end else if (stat.full) begin
              cmd.load_res   = fin_ok;
              cmd.res_status = plid_pkg::ST_FULL;
            end else begin
              cmd.load_idx_ins = 1'b1;
            end
          end
          plid_pkg::OP_DELETE: begin
            if (stat.pos_lt_count) cmd.load_idx_del = 1'b1;
            else                   cmd.load_res     = fin_ok;
          end
          plid_pkg::OP_READ: begin
            if (stat.pos_lt_count) cmd.rd_pos   = 1'b1;
            else                   cmd.load_res = fin_ok;
          end
          default: begin
            cmd.load_res = fin_ok;
          end
        endcase
      end
      plid_pkg::S_STEP: begin
        if (stat.op == plid_pkg::OP_INSERT) begin
          if (stat.ins_at_pos) begin
            cmd.wr_item    = fin_ok;
            cmd.inc        = fin_ok;
            cmd.load_res   = fin_ok;
            cmd.res_status = plid_pkg::ST_DONE;
          end else begin
            cmd.rd_step = 1'b1;
          end
        end else begin
          if (stat.del_tail) begin
            cmd.dec        = fin_ok;
            cmd.load_res   = fin_ok;
            cmd.res_status = plid_pkg::ST_DONE;
          end else begin
            cmd.rd_step = 1'b1;
          end
        end
      end
      plid_pkg::S_SHIFT: begin
        cmd.wr_shift = 1'b1;
      end
      plid_pkg::S_READ: begin
        cmd.load_res      = fin_ok;
        cmd.res_status    = plid_pkg::ST_DONE;
        cmd.res_use_rdata = 1'b1;
      end
      default: begin
        cmd.latch_in = 1'b0;
      end
    endcase
  end

endmodule

### src/plid_dp.sv
// Datapath: entry memory, count, shift index and result registers.
module plid_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [plid_pkg::OP_W-1:0]     in_op,
  input  logic [plid_pkg::POS_W-1:0]    in_position,
  input  logic [plid_pkg::ITEM_W-1:0]   in_item,
  input  plid_pkg::cmd_t                cmd,
  output plid_pkg::stat_t               stat,
  output logic [plid_pkg::STAT_W-1:0]   status,
  output logic [plid_pkg::ITEM_W-1:0]   read_value,
  output logic [plid_pkg::OUTCNT_W-1:0] count
);

  logic [plid_pkg::ITEM_W-1:0] mem [plid_pkg::DEPTH];

  logic [plid_pkg::OP_W-1:0]   op;
  logic [plid_pkg::POS_W-1:0]  pos;
  logic [plid_pkg::ITEM_W-1:0] item;
  logic [plid_pkg::CNT_W-1:0]  cnt;
  logic [plid_pkg::CNT_W-1:0]  cnt_next;
  logic [plid_pkg::CNT_W-1:0]  idx;
  logic [plid_pkg::CNT_W-1:0]  idx_nb;   // neighbor in shift direction
  logic [plid_pkg::ITEM_W-1:0] rdata;
  logic [plid_pkg::CMP_W-1:0]  pos_ext;
  logic [plid_pkg::CMP_W-1:0]  cnt_ext;
  logic [plid_pkg::ADDR_W-1:0] rd_addr;

  assign pos_ext = plid_pkg::CMP_W'(pos);
  assign cnt_ext = plid_pkg::CMP_W'(cnt);
  assign idx_nb  = (op == plid_pkg::OP_INSERT) ? idx - 1'b1 : idx + 1'b1;
  assign rd_addr = cmd.rd_pos ? pos_ext[plid_pkg::ADDR_W-1:0] : idx_nb[plid_pkg::ADDR_W-1:0];

  always_comb begin
    cnt_next = cnt;
    if (cmd.inc)      cnt_next = cnt + 1'b1;
    else if (cmd.dec) cnt_next = cnt - 1'b1;
  end

  assign stat.op           = op;
  assign stat.pos_le_count = (pos_ext <= cnt_ext);
  assign stat.pos_lt_count = (pos_ext < cnt_ext);
  assign stat.full         = (cnt == plid_pkg::CNT_W'(plid_pkg::DEPTH));
  assign stat.ins_at_pos   = (plid_pkg::CMP_W'(idx) == pos_ext);
  // idx + 1 >= count: nothing above idx left to pull down
  assign stat.del_tail     = ((plid_pkg::CMP_W'(idx) + 1'b1) >= cnt_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op   <= in_op;
      pos  <= in_position;
      item <= in_item;
    end
    if (cmd.load_idx_ins)      idx <= cnt;
    else if (cmd.load_idx_del) idx <= plid_pkg::CNT_W'(pos);
    else if (cmd.wr_shift)     idx <= idx_nb;
    if (cmd.load_res) begin
      status     <= cmd.res_status;
      read_value <= cmd.res_use_rdata ? rdata : '0;
      count      <= plid_pkg::OUTCNT_W'(cnt_next);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_pos || cmd.rd_step) begin
      rdata <= mem[rd_addr];
    end
    if (cmd.wr_shift) begin
      mem[idx[plid_pkg::ADDR_W-1:0]] <= rdata;
    end else if (cmd.wr_item) begin
      mem[pos_ext[plid_pkg::ADDR_W-1:0]] <= item;
    end
  end

endmodule

### src/positional_list_insert_delete.sv
// Top level of the positional list: stream ports, controller and datapath.
//
// Ordered list of up to 128 signed 32-bit entries held in a single-port-read,
// single-port-write memory. One transaction is worked at a time. After the
// input transaction is taken, an error result is registered from the check
// state, a read result after its memory read, and an insert or delete result
// after the entries from the position to the end of the list are shifted: each
// moved entry takes one memory read and one memory write. The next input is
// taken in the cycle after the result is registered; the result register holds
// the output transaction until it is taken, and work on the next one may
// proceed meanwhile. Reset leaves the list empty; no clearing pass is needed.
module positional_list_insert_delete (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // op[1:0], position[9:2], item[41:10], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // status[1:0], read_value[33:2], count[41:34], zero fill
);

  plid_pkg::cmd_t  cmd;
  plid_pkg::stat_t stat;

  logic [plid_pkg::STAT_W-1:0]   status;
  logic [plid_pkg::ITEM_W-1:0]   read_value;
  logic [plid_pkg::OUTCNT_W-1:0] count;

  plid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  plid_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_op       (s_tdata[1:0]),
    .in_position (s_tdata[9:2]),
    .in_item     (s_tdata[41:10]),
    .cmd         (cmd),
    .stat        (stat),
    .status      (status),
    .read_value  (read_value),
    .count       (count)
  );

  assign m_tdata = {6'd0, count, read_value, status};

endmodule

### src/plid_checker.sv
// Port-level checker for the positional list, bound to the top level.
`include "positional_list_insert_delete_defines.svh"

module plid_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [47:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  `PLID_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
  `PLID_ASSERT(a_status_code, m_tvalid |-> m_tdata[1:0] <= plid_pkg::ST_FULL, "undefined status code")
  `PLID_ASSERT(a_err_zero, m_tvalid && m_tdata[1:0] != plid_pkg::ST_DONE |-> m_tdata[33:2] == 32'd0, "error result carries data")
  `PLID_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "second transaction taken before the first finished")
  `PLID_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_tvalid, "result pending after reset")

endmodule

bind positional_list_insert_delete plid_checker u_plid_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/sv/tb_positional_list_insert_delete.sv
// Self-checking stream testbench for the positional list insert/delete block.
module tb_positional_list_insert_delete;

  localparam logic [plid_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [31:0] WORD_MAX  = 32'h7fff_ffff;
  localparam logic [31:0] WORD_MIN  = 32'h8000_0000;
  localparam logic [31:0] WORD_NEG1 = 32'hffff_ffff;
  localparam int DIR_ROWS    = 25;
  localparam int RAND_ITEMS  = 1330;
  localparam int HOLD_AT     = 200;
  localparam int SINK_HOLD   = 600;
  localparam int SETTLE      = 2 * plid_pkg::DEPTH + 16;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [plid_pkg::STAT_W-1:0] status;
    logic [31:0]                 read_value;
    logic [7:0]                  count;
  } list_result_t;

  typedef struct packed {
    logic [plid_pkg::OP_W-1:0] op;
    logic [7:0]                pos;
    logic [31:0]               item;
    logic                      typed;
    list_result_t              res;
  } dir_row_t;

  typedef enum int {FILL_PHASE, MIX_PHASE, DRAIN_PHASE, GROW_PHASE, SHRINK_PHASE} phase_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // op[1:0], position[9:2], item[41:10], zero fill
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // status[1:0], read_value[33:2], count[41:34], zero fill

  // shadow copy of the list
  logic [31:0]  list_words [plid_pkg::DEPTH];
  int           list_len;
  list_result_t pending_results [$];
  int           fail_count;
  int           burst_left;
  bit           sink_hold_req;
  dir_row_t     directed_rows [DIR_ROWS];
  list_result_t exp_res;
  list_result_t got_res;

  positional_list_insert_delete i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic apply_list_op(input logic [plid_pkg::OP_W-1:0] op, input logic [7:0] pos,
                               input logic [31:0] item, output list_result_t r);
    int p;
    int i;
    p = pos;
    r.status     = plid_pkg::ST_BADPOS;
    r.read_value = '0;
    case (op)
      plid_pkg::OP_INSERT: begin
        if (p > list_len) begin
          r.status = plid_pkg::ST_BADPOS;
        end else if (list_len >= plid_pkg::DEPTH) begin
          r.status = plid_pkg::ST_FULL;
        end else begin
          for (i = list_len; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = item;
          list_len++;
          r.status = plid_pkg::ST_DONE;
        end
      end
      plid_pkg::OP_DELETE: begin
        if (p < list_len) begin
          for (i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          r.status = plid_pkg::ST_DONE;
        end
      end
      plid_pkg::OP_READ: begin
        if (p < list_len) begin
          r.read_value = list_words[p];
          r.status     = plid_pkg::ST_DONE;
        end
      end
      default: ;
    endcase
    r.count = list_len[7:0];
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic offer_op(input logic [plid_pkg::OP_W-1:0] op, input logic [7:0] pos,
                          input logic [31:0] item, input logic typed,
                          input list_result_t typed_res);
    list_result_t pred;
    s_tdata  <= {6'b0, item, pos, op};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_list_op(op, pos, item, pred);
    pending_results.push_back(typed ? typed_res : pred);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(99);
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      if (r < 55) gap = 0;
      else if (r < 88) gap = $urandom_range(3, 1);
      else gap = $urandom_range(40, 6);
      if ($urandom_range(19) == 0) burst_left = $urandom_range(60, 20);
    end
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic [plid_pkg::OP_W-1:0] pick_op(input phase_t phase);
    int unsigned r;
    int ins_w;
    int del_w;
    int rd_w;
    r = $urandom_range(99);
    case (phase)
      FILL_PHASE:   begin ins_w = 88; del_w = 2;  rd_w = 8;  end
      DRAIN_PHASE:  begin ins_w = 2;  del_w = 88; rd_w = 8;  end
      GROW_PHASE:   begin ins_w = 60; del_w = 15; rd_w = 20; end
      SHRINK_PHASE: begin ins_w = 15; del_w = 60; rd_w = 20; end
      default:      begin ins_w = 33; del_w = 30; rd_w = 30; end
    endcase
    if (r < ins_w) return plid_pkg::OP_INSERT;
    else if (r < ins_w + del_w) return plid_pkg::OP_DELETE;
    else if (r < ins_w + del_w + rd_w) return plid_pkg::OP_READ;
    return OP_UNUSED;
  endfunction

  function automatic logic [7:0] pick_position(input logic [plid_pkg::OP_W-1:0] op);
    int unsigned r;
    int top;
    r   = $urandom_range(99);
    top = (op == plid_pkg::OP_INSERT) ? list_len : list_len - 1;
    if (r < 8) return 8'($urandom_range(255));
    if (r < 14) begin
      case ($urandom_range(3))
        0: return 8'd0;
        1: return 8'(list_len);
        2: return 8'((list_len > 0) ? list_len - 1 : 0);
        default: return 8'd255;
      endcase
    end
    if (top < 0) return 8'd0;
    return 8'($urandom_range(top, 0));
  endfunction

  function automatic logic [31:0] pick_word();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: return WORD_MAX;
        1: return WORD_MIN;
        2: return 32'd0;
        default: return WORD_NEG1;
      endcase
    end
    return $urandom;
  endfunction

  initial begin : stimulus
    phase_t                    phase;
    int                        phase_idx;
    int                        phase_len;
    int                        at_edge;
    int                        k;
    int                        rand_sent;
    bit                        phase_over;
    logic [plid_pkg::OP_W-1:0] op;
    logic [7:0]                pos;
    list_result_t              no_res;

    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    list_len      = 0;
    fail_count    = 0;
    burst_left    = 0;
    sink_hold_req = 1'b0;
    no_res        = '0;

    directed_rows = '{
      '{plid_pkg::OP_READ, 8'd0, 32'd0, 1'b1, '{plid_pkg::ST_BADPOS, 32'd0, 8'd0}},
      '{plid_pkg::OP_DELETE, 8'd0, 32'd0, 1'b1, '{plid_pkg::ST_BADPOS, 32'd0, 8'd0}},
      '{plid_pkg::OP_INSERT, 8'd1, WORD_MAX, 1'b1, '{plid_pkg::ST_BADPOS, 32'd0, 8'd0}},
      '{OP_UNUSED, 8'd0, WORD_NEG1, 1'b1, '{plid_pkg::ST_BADPOS, 32'd0, 8'd0}},
      '{plid_pkg::OP_INSERT, 8'd0, WORD_MAX, 1'b1, '{plid_pkg::ST_DONE, 32'd0, 8'd1}},
      '{plid_pkg::OP_INSERT, 8'd1, WORD_MIN, 1'b1, '{plid_pkg::ST_DONE, 32'd0, 8'd2}},
      '{plid_pkg::OP_INSERT, 8'd0, WORD_NEG1, 1'b1, '{plid_pkg::ST_DONE, 32'd0, 8'd3}},
      '{plid_pkg::OP_INSERT, 8'd3, 32'd0, 1'b1, '{plid_pkg::ST_DONE, 32'd0, 8'd4}},
      '{plid_pkg::OP_READ, 8'd0, 32'd0, 1'b1, '{plid_pkg::ST_DONE, WORD_NEG1, 8'd4}},
      '{plid_pkg::OP_READ, 8'd1, 32'd0, 1'b1, '{plid_pkg::ST_DONE, WORD_MAX, 8'd4}},
      '{plid_pkg::OP_READ, 8'd2, 32'd0, 1'b1, '{plid_pkg::ST_DONE, WORD_MIN, 8'd4}},
      '{plid_pkg::OP_READ, 8'd3, WORD_NEG1, 1'b1, '{plid_pkg::ST_DONE, 32'd0, 8'd4}},
      '{plid_pkg::OP_READ, 8'd4, 32'd0, 1'b1, '{plid_pkg::ST_BADPOS, 32'd0, 8'd4}},
      '{plid_pkg::OP_READ, 8'd255, 32'd0, 1'b1, '{plid_pkg::ST_BADPOS, 32'd0, 8'd4}},
      '{plid_pkg::OP_INSERT, 8'd5, 32'h5a5a_5a5a, 1'b1, '{plid_pkg::ST_BADPOS, 32'd0, 8'd4}},
      '{plid_pkg::OP_INSERT, 8'd255, 32'ha5a5_a5a5, 1'b1,
        '{plid_pkg::ST_BADPOS, 32'd0, 8'd4}},
      '{plid_pkg::OP_DELETE, 8'd4, 32'd0, 1'b1, '{plid_pkg::ST_BADPOS, 32'd0, 8'd4}},
      '{plid_pkg::OP_DELETE, 8'd255, WORD_NEG1, 1'b1, '{plid_pkg::ST_BADPOS, 32'd0, 8'd4}},
      '{OP_UNUSED, 8'd255, WORD_NEG1, 1'b1, '{plid_pkg::ST_BADPOS, 32'd0, 8'd4}},
      '{plid_pkg::OP_DELETE, 8'd1, 32'd0, 1'b1, '{plid_pkg::ST_DONE, 32'd0, 8'd3}},
      '{plid_pkg::OP_READ, 8'd1, 32'd0, 1'b1, '{plid_pkg::ST_DONE, WORD_MIN, 8'd3}},
      '{plid_pkg::OP_DELETE, 8'd2, 32'd0, 1'b1, '{plid_pkg::ST_DONE, 32'd0, 8'd2}},
      '{plid_pkg::OP_DELETE, 8'd0, 32'd0, 1'b1, '{plid_pkg::ST_DONE, 32'd0, 8'd1}},
      '{plid_pkg::OP_READ, 8'd0, 32'd0, 1'b1, '{plid_pkg::ST_DONE, WORD_MIN, 8'd1}},
      '{plid_pkg::OP_INSERT, 8'd1, 32'h1234_5678, 1'b0, '{plid_pkg::ST_DONE, 32'd0, 8'd0}}
    };

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[n]) begin
      offer_op(directed_rows[n].op, directed_rows[n].pos, directed_rows[n].item,
               directed_rows[n].typed, directed_rows[n].res);
      pause_sender();
    end

    // phases alternate so the list fills to the top and empties several times
    rand_sent = 0;
    phase_idx = 0;
    while (rand_sent < RAND_ITEMS) begin
      phase      = phase_t'(phase_idx % 5);
      phase_idx++;
      phase_len  = $urandom_range(120, 40);
      at_edge    = 0;
      k          = 0;
      phase_over = 1'b0;
      while (!phase_over && k < 400 && rand_sent < RAND_ITEMS) begin
        op = pick_op(phase);
        if (phase == FILL_PHASE && op == plid_pkg::OP_INSERT && list_len == plid_pkg::DEPTH)
          at_edge++;
        if (phase == DRAIN_PHASE && op == plid_pkg::OP_DELETE && list_len == 0) at_edge++;
        pos = pick_position(op);
        offer_op(op, pos, pick_word(), 1'b0, no_res);
        pause_sender();
        k++;
        rand_sent++;
        if (rand_sent == HOLD_AT) sink_hold_req = 1'b1;
        if (phase == FILL_PHASE || phase == DRAIN_PHASE) phase_over = (at_edge >= 6);
        else phase_over = (k >= phase_len);
      end
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("positional_list_insert_delete regression: pass");
    end else begin
      $display("positional_list_insert_delete regression: fail");
    end
    $finish;
  end

  // result side pacing, with one long hold-off so the block backs up
  initial begin : sink_pacing
    int unsigned r;
    int unsigned on_len;
    int unsigned off_len;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (SINK_HOLD) @(negedge clk);
      end
      r = $urandom_range(99);
      if (r < 20) begin
        on_len  = $urandom_range(80, 20);
        off_len = 0;
      end else begin
        on_len  = $urandom_range(6, 1);
        off_len = (r < 90) ? $urandom_range(3, 1) : $urandom_range(50, 8);
      end
      m_tready <= 1'b1;
      repeat (on_len) @(negedge clk);
      if (off_len != 0) begin
        m_tready <= 1'b0;
        repeat (off_len) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res = '{m_tdata[1:0], m_tdata[33:2], m_tdata[41:34]};
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected: %h", m_tdata);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (got_res.status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, got_res.status);
          fail_count++;
        end
        if (got_res.read_value !== exp_res.read_value) begin
          $error("read_value: expected %0d, actual %0d",
                 $signed(exp_res.read_value), $signed(got_res.read_value));
          fail_count++;
        end
        if (got_res.count !== exp_res.count) begin
          $error("count: expected %0d, actual %0d", exp_res.count, got_res.count);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("positional_list_insert_delete regression: fail");
    $finish;
  end

endmodule
